[rtl/tlang_pkg.sv]
// tlang_pkg: shared types, constants and the angle table builder for two_row_line_angle
// no dependencies; used by every module of the block
`default_nettype none

package tlang_pkg;

  // default tracked rows
  localparam logic [7:0] FAR_ROW_DEFAULT  = 8'd35;
  localparam logic [7:0] NEAR_ROW_DEFAULT = 8'd70;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_ROW        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FRAMES     = 3'd5;

  // configuration reset values
  localparam logic [7:0] ROI_LEFT_RESET       = 8'd0;
  localparam logic [7:0] ROI_RIGHT_RESET      = 8'd159;
  localparam logic [7:0] MIN_RUN_RESET        = 8'd3;
  localparam logic [7:0] RED_ROW_RESET        = 8'd65;
  localparam logic [7:0] RED_THRESHOLD_RESET  = 8'd8;
  localparam logic [3:0] RED_FRAMES_RESET     = 4'd3;

  // which row the run registers belong to
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_FAR  = 2'd1;
  localparam logic [1:0] SIDE_NEAR = 2'd2;

  localparam logic [8:0] SAT9      = 9'd511;
  localparam logic [7:0] CODE_MID  = 8'd127;
  localparam logic [7:0] CODE_MAX  = 8'd254;

  // row results handed from the run tracker to the top level
  typedef struct packed {
    logic       far_found;
    logic [7:0] far_center;
    logic [7:0] far_width;
    logic       near_found;
    logic [7:0] near_center;
    logic [7:0] near_width;
  } row_res_t;

  typedef logic [255:0][7:0] angle_rom_t;

  // cordic angles in units of 2^-20 degree
  localparam int CORDIC_STEPS = 24;
  localparam longint CORDIC_ANGLE [CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  function automatic longint shr_sym(longint v, int s);
    if (v < 0) begin
      return -((-v) >>> s);
    end
    return v >>> s;
  endfunction

  // round(127 + atan2(dx, dy) in degrees), clamped to 0..254; elaboration only
  function automatic logic [7:0] angle_code_of(int dx, int dy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint deg;
    longint v;
    longint r;
    x = longint'(dy < 0 ? -dy : dy) * 64'sd16777216;
    y = longint'(dx < 0 ? -dx : dx) * 64'sd16777216;
    z = 0;
    if (x != 0 || y != 0) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = shr_sym(x, i);
        ys = shr_sym(y, i);
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + CORDIC_ANGLE[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - CORDIC_ANGLE[i];
        end
      end
    end
    deg = (dy < 0) ? (64'sd180 * 64'sd1048576) - z : z;
    if (dx < 0) begin
      deg = -deg;
    end
    v = 64'sd127 * 64'sd1048576 + deg;
    if (v >= 0) begin
      r = (v + 64'sd524288) >>> 20;
    end else begin
      r = -(((-v) + 64'sd524288) >>> 20);
    end
    if (r < 0) begin
      r = 0;
    end
    if (r > 254) begin
      r = 254;
    end
    return r[7:0];
  endfunction

  // code table over |dx| for one sign of dx
  function automatic angle_rom_t build_angle_rom(bit neg, int dy);
    angle_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = angle_code_of(neg ? -i : i, dy);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

[rtl/tlang_row_track.sv]
// tlang_row_track: longest black run tracking on the far and near rows
// depends on tlang_pkg
`default_nettype none

module tlang_row_track #(
  parameter logic [7:0] FAR_ROW  = tlang_pkg::FAR_ROW_DEFAULT,
  parameter logic [7:0] NEAR_ROW = tlang_pkg::NEAR_ROW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic [7:0]          px,
  input  wire logic [7:0]          py,
  input  wire logic                black,
  input  wire logic                in_roi,
  input  wire logic                fend,
  input  wire logic [7:0]          min_run_length,
  output tlang_pkg::row_res_t      res
);

  logic [7:0] run_start;
  logic [8:0] run_len;
  logic [7:0] best_start;
  logic [8:0] best_len;
  logic [1:0] track_side;
  logic       far_found;
  logic [7:0] far_center_hold;
  logic [7:0] far_width_hold;

  logic [7:0] run_start_next;
  logic [8:0] run_len_next;
  logic [7:0] best_start_next;
  logic [8:0] best_len_next;
  logic [1:0] track_side_next;
  logic       far_found_next;
  logic [7:0] far_center_hold_next;
  logic [7:0] far_width_hold_next;

  logic       on_far;
  logic       on_near;
  logic       tracked;
  logic [1:0] side;
  logic [7:0] rs0;
  logic [8:0] rl0;
  logic [7:0] bs0;
  logic [8:0] bl0;
  logic       grow;
  logic [7:0] cur_start;
  logic [8:0] cur_len;
  logic       cur_found;
  logic [7:0] cur_center;
  logic [7:0] cur_width;

  assign on_far  = (py == FAR_ROW);
  assign on_near = (py == NEAR_ROW);
  assign tracked = on_far || on_near;
  assign side    = on_near ? tlang_pkg::SIDE_NEAR : tlang_pkg::SIDE_FAR;
  assign grow    = tracked && in_roi && black;

  always_comb begin
    // switching rows drops the other row's run state first
    if (tracked && (side != track_side)) begin
      rs0 = '0;
      rl0 = '0;
      bs0 = '0;
      bl0 = '0;
      track_side_next = side;
    end else begin
      rs0 = run_start;
      rl0 = run_len;
      bs0 = best_start;
      bl0 = best_len;
      track_side_next = track_side;
    end

    run_start_next  = rs0;
    best_start_next = bs0;
    best_len_next   = bl0;
    if (grow) begin
      if (rl0 == '0) begin
        run_start_next = px;
      end
      run_len_next = (rl0 < tlang_pkg::SAT9) ? rl0 + 9'd1 : rl0;
    end else begin
      if (rl0 > bl0) begin
        best_len_next   = rl0;
        best_start_next = rs0;
      end
      run_len_next = '0;
    end
  end

  // longest run so far with the open one included
  always_comb begin
    if (run_len_next > best_len_next) begin
      cur_len   = run_len_next;
      cur_start = run_start_next;
    end else begin
      cur_len   = best_len_next;
      cur_start = best_start_next;
    end
    cur_found  = (cur_len != '0) && (cur_len >= {1'b0, min_run_length});
    cur_center = cur_found ? cur_start + cur_len[8:1] : 8'd0;
    cur_width  = cur_found ? (cur_len[8] ? 8'd255 : cur_len[7:0]) : 8'd0;
  end

  always_comb begin
    if (on_far) begin
      far_found_next       = cur_found;
      far_center_hold_next = cur_center;
      far_width_hold_next  = cur_width;
    end else begin
      far_found_next       = far_found;
      far_center_hold_next = far_center_hold;
      far_width_hold_next  = far_width_hold;
    end
  end

  always_comb begin
    res.far_found   = far_found_next;
    res.far_center  = far_found_next ? far_center_hold_next : 8'd0;
    res.far_width   = far_found_next ? far_width_hold_next : 8'd0;
    res.near_found  = (track_side_next == tlang_pkg::SIDE_NEAR) && cur_found;
    res.near_center = res.near_found ? cur_center : 8'd0;
    res.near_width  = res.near_found ? cur_width : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (en && fend)) begin
      run_start       <= '0;
      run_len         <= '0;
      best_start      <= '0;
      best_len        <= '0;
      track_side      <= tlang_pkg::SIDE_NONE;
      far_found       <= 1'b0;
      far_center_hold <= '0;
      far_width_hold  <= '0;
    end else if (en) begin
      run_start       <= run_start_next;
      run_len         <= run_len_next;
      best_start      <= best_start_next;
      best_len        <= best_len_next;
      track_side      <= track_side_next;
      far_found       <= far_found_next;
      far_center_hold <= far_center_hold_next;
      far_width_hold  <= far_width_hold_next;
    end
  end

endmodule

`default_nettype wire

[rtl/tlang_red_count.sv]
// tlang_red_count: red pixel count on one row and the red frame streak
// depends on tlang_pkg
`default_nettype none

module tlang_red_count (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [7:0] py,
  input  wire logic       red,
  input  wire logic       in_roi,
  input  wire logic       fend,
  input  wire logic [7:0] red_row,
  input  wire logic [7:0] red_threshold,
  input  wire logic [3:0] red_frames_needed,
  output logic            red_confirmed
);

  logic [8:0] red_pixel_count;
  logic [8:0] red_pixel_count_next;
  logic [3:0] red_streak;
  logic [3:0] red_streak_next;

  always_comb begin
    red_pixel_count_next = red_pixel_count;
    if ((py == red_row) && in_roi && red && (red_pixel_count < tlang_pkg::SAT9)) begin
      red_pixel_count_next = red_pixel_count + 9'd1;
    end
    if (red_pixel_count_next >= {1'b0, red_threshold}) begin
      red_streak_next = (red_streak < red_frames_needed) ? red_streak + 4'd1 : red_streak;
    end else begin
      red_streak_next = '0;
    end
  end

  assign red_confirmed = (red_streak_next >= red_frames_needed);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_pixel_count <= '0;
      red_streak      <= '0;
    end else if (en) begin
      if (fend) begin
        red_pixel_count <= '0;
        red_streak      <= red_streak_next;
      end else begin
        red_pixel_count <= red_pixel_count_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tlang_angle.sv]
// tlang_angle: angle code lookup from the two run centres
// depends on tlang_pkg (table builder)
`default_nettype none

module tlang_angle #(
  parameter logic [7:0] FAR_ROW  = tlang_pkg::FAR_ROW_DEFAULT,
  parameter logic [7:0] NEAR_ROW = tlang_pkg::NEAR_ROW_DEFAULT
) (
  input  wire logic       valid,
  input  wire logic [7:0] near_center,
  input  wire logic [7:0] far_center,
  output logic [7:0]      angle_code
);

  localparam int DY = int'(NEAR_ROW) - int'(FAR_ROW);
  localparam tlang_pkg::angle_rom_t ROM_POS = tlang_pkg::build_angle_rom(1'b0, DY);
  localparam tlang_pkg::angle_rom_t ROM_NEG = tlang_pkg::build_angle_rom(1'b1, DY);

  logic [8:0] dx;
  logic       neg;
  logic [7:0] mag;

  assign dx  = {1'b0, near_center} - {1'b0, far_center};
  assign neg = dx[8];
  assign mag = neg ? 8'(-dx) : dx[7:0];

  always_comb begin
    if (!valid) begin
      angle_code = tlang_pkg::CODE_MID;
    end else if (neg) begin
      angle_code = ROM_NEG[mag];
    end else begin
      angle_code = ROM_POS[mag];
    end
  end

endmodule

`default_nettype wire

[rtl/two_row_line_angle.sv]
// two_row_line_angle: line angle from two fixed pixel rows, red frame detection
// depends on tlang_pkg, tlang_row_track, tlang_red_count, tlang_angle
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | pix_x, pix_y, is_black, is_red, frame_end
//   out     | out_valid/ out_ready | fine_valid, angle_code, far_center, near_center,
//           |                      | far_width, near_width, red_confirmed
//   cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one pixel item per cycle unless a frame_end pixel waits on a stalled result; each item
// passes the input register and, if it is the frame_end pixel, the result register too;
// the run, red count and angle table lookup all sit between those two registers
// synchronous active high reset clears the run state, red streak and both valids,
// and loads the configuration reset values
// a stalled result only holds back the next frame_end pixel; ordinary pixels
// keep flowing past a waiting result
`default_nettype none

module two_row_line_angle #(
  parameter logic [7:0] FAR_ROW  = tlang_pkg::FAR_ROW_DEFAULT,
  parameter logic [7:0] NEAR_ROW = tlang_pkg::NEAR_ROW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // pixel items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     pix_x,
  input  wire logic [7:0]                     pix_y,
  input  wire logic                           is_black,
  input  wire logic                           is_red,
  input  wire logic                           frame_end,
  // frame results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                fine_valid,
  output logic [7:0]                          angle_code,
  output logic [7:0]                          far_center,
  output logic [7:0]                          near_center,
  output logic [7:0]                          far_width,
  output logic [7:0]                          near_width,
  output logic                                red_confirmed,
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tlang_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  // configuration registers
  logic [7:0] roi_left;
  logic [7:0] roi_right;
  logic [7:0] min_run_length;
  logic [7:0] red_row;
  logic [7:0] red_threshold;
  logic [3:0] red_frames_needed;

  // input register
  logic       s1_valid;
  logic [7:0] s1_x;
  logic [7:0] s1_y;
  logic       s1_black;
  logic       s1_red;
  logic       s1_fend;

  logic                s1_fire;
  logic                s1_in_roi;
  tlang_pkg::row_res_t rows;
  logic                red_now;
  logic [7:0]          code_now;
  logic                valid_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left          <= tlang_pkg::ROI_LEFT_RESET;
      roi_right         <= tlang_pkg::ROI_RIGHT_RESET;
      min_run_length    <= tlang_pkg::MIN_RUN_RESET;
      red_row           <= tlang_pkg::RED_ROW_RESET;
      red_threshold     <= tlang_pkg::RED_THRESHOLD_RESET;
      red_frames_needed <= tlang_pkg::RED_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlang_pkg::CFG_ROI_LEFT:       roi_left          <= cfg_data;
        tlang_pkg::CFG_ROI_RIGHT:      roi_right         <= cfg_data;
        tlang_pkg::CFG_MIN_RUN_LENGTH: min_run_length    <= cfg_data;
        tlang_pkg::CFG_RED_ROW:        red_row           <= cfg_data;
        tlang_pkg::CFG_RED_THRESHOLD:  red_threshold     <= cfg_data;
        tlang_pkg::CFG_RED_FRAMES:     red_frames_needed <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // a frame_end item moves on only when the result register can take it
  assign s1_fire  = s1_valid && (!s1_fend || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x     <= pix_x;
      s1_y     <= pix_y;
      s1_black <= is_black;
      s1_red   <= is_red;
      s1_fend  <= frame_end;
    end
  end

  // an empty window (left above right) holds no pixel
  assign s1_in_roi = (s1_x >= roi_left) && (s1_x <= roi_right);

  tlang_row_track #(
    .FAR_ROW  (FAR_ROW),
    .NEAR_ROW (NEAR_ROW)
  ) u_row_track (
    .clk            (clk),
    .rst            (rst),
    .en             (s1_fire),
    .px             (s1_x),
    .py             (s1_y),
    .black          (s1_black),
    .in_roi         (s1_in_roi),
    .fend           (s1_fend),
    .min_run_length (min_run_length),
    .res            (rows)
  );

  tlang_red_count u_red_count (
    .clk               (clk),
    .rst               (rst),
    .en                (s1_fire),
    .py                (s1_y),
    .red               (s1_red),
    .in_roi            (s1_in_roi),
    .fend              (s1_fend),
    .red_row           (red_row),
    .red_threshold     (red_threshold),
    .red_frames_needed (red_frames_needed),
    .red_confirmed     (red_now)
  );

  assign valid_now = rows.far_found && rows.near_found;

  tlang_angle #(
    .FAR_ROW  (FAR_ROW),
    .NEAR_ROW (NEAR_ROW)
  ) u_angle (
    .valid       (valid_now),
    .near_center (rows.near_center),
    .far_center  (rows.far_center),
    .angle_code  (code_now)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_fend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_fend) begin
      fine_valid    <= valid_now;
      angle_code    <= code_now;
      far_center    <= rows.far_center;
      near_center   <= rows.near_center;
      far_width     <= rows.far_width;
      near_width    <= rows.near_width;
      red_confirmed <= red_now;
    end
  end

endmodule

`default_nettype wire

[rtl/tlang_check.sv]
// tlang_check: port level checks for two_row_line_angle, bound to the top level
// depends on tlang_pkg and the top level's ports
`default_nettype none

module tlang_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       fine_valid,
  input wire logic [7:0] angle_code,
  input wire logic [7:0] far_center,
  input wire logic [7:0] far_width,
  input wire logic [7:0] near_width
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_code) && $stable(far_width))
    else $error("result changed while stalled");

  // no line means the straight ahead code
  a_code_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fine_valid |-> angle_code == tlang_pkg::CODE_MID)
    else $error("angle code set without a line");

  // a line needs a run on both rows
  a_valid_widths: assert property (@(posedge clk) disable iff (rst)
    out_valid && fine_valid |-> far_width != 8'd0 && near_width != 8'd0
      && angle_code <= tlang_pkg::CODE_MAX)
    else $error("line reported without runs");

  // no far run means no far centre
  a_far_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && far_width == 8'd0 |-> far_center == 8'd0)
    else $error("far centre without far run");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_row_line_angle tlang_check u_tlang_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .fine_valid (fine_valid),
  .angle_code (angle_code),
  .far_center (far_center),
  .far_width  (far_width),
  .near_width (near_width)
);

`default_nettype wire

[sim/testbench.sv]
// testbench for two_row_line_angle: sparse pixel frames, register phases and random idling
// a scoreboard class predicts every frame result and checks it field by field
// depends on tlang_pkg and the two_row_line_angle rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // tracked rows of the instance (block defaults)
  localparam logic [7:0] FAR_Y  = tlang_pkg::FAR_ROW_DEFAULT;
  localparam logic [7:0] NEAR_Y = tlang_pkg::NEAR_ROW_DEFAULT;
  // index with no register behind it, writes there are ignored
  localparam logic [tlang_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  localparam logic [7:0] LEVEL_CODE = 8'd127;
  localparam logic [7:0] TOP_CODE   = 8'd254;
  localparam logic [8:0] COUNT_CAP  = 9'd511;
  localparam int MAX_IDLE    = 14;
  localparam int SETTLE      = 4;    // pipeline is two registers deep
  localparam int DRAIN_LIMIT = 2000;
  localparam int PHASE_ITEMS = 105;
  localparam int PHASE_FRAMES = 4;
  localparam int LONG_RUN    = 515;

  // atan(2^-k) in units of 2^-20 degree
  localparam longint ATAN_STEP [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic       fine_valid;
    logic [7:0] angle_code;
    logic [7:0] far_center;
    logic [7:0] near_center;
    logic [7:0] far_width;
    logic [7:0] near_width;
    logic       red_confirmed;
  } frame_res_t;

  typedef enum logic [1:0] {ROW_NONE, ROW_FAR, ROW_NEAR} row_side_e;

  // predicts frame results from accepted pixels and checks what comes out
  class line_angle_board;
    logic [7:0] roi_left, roi_right, min_len, red_row, red_needed_px;
    logic [3:0] red_frames;
    logic [7:0] open_start, top_start;
    logic [8:0] open_len, top_len;
    row_side_e  side;
    logic       far_ok;
    logic [7:0] far_mid, far_wid;
    logic [8:0] red_px;
    logic [3:0] red_run;
    frame_res_t expected_q[$];
    int errors, frames_expected, frames_checked, angles_seen, red_seen;

    function new();
      roi_left = 8'd0;
      roi_right = 8'd159;
      min_len = 8'd3;
      red_row = 8'd65;
      red_needed_px = 8'd8;
      red_frames = 4'd3;
      clear_row();
      side = ROW_NONE;
      far_ok = 1'b0;
      far_mid = 8'd0;
      far_wid = 8'd0;
      red_px = 9'd0;
      red_run = 4'd0;
      errors = 0;
      frames_expected = 0;
      frames_checked = 0;
      angles_seen = 0;
      red_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        tlang_pkg::CFG_ROI_LEFT:       roi_left = data;
        tlang_pkg::CFG_ROI_RIGHT:      roi_right = data;
        tlang_pkg::CFG_MIN_RUN_LENGTH: min_len = data;
        tlang_pkg::CFG_RED_ROW:        red_row = data;
        tlang_pkg::CFG_RED_THRESHOLD:  red_needed_px = data;
        tlang_pkg::CFG_RED_FRAMES:     red_frames = data[3:0];
        default: ;
      endcase
    endfunction

    function void clear_row();
      open_start = 8'd0;
      open_len = 9'd0;
      top_start = 8'd0;
      top_len = 9'd0;
    endfunction

    function void close_open();
      if (open_len > top_len) begin
        top_len = open_len;
        top_start = open_start;
      end
      open_len = 9'd0;
    endfunction

    // longest run of the row so far, open run included
    function logic row_best(output logic [7:0] mid, output logic [7:0] wid);
      logic [7:0] s;
      logic [8:0] l;
      logic [8:0] sum;
      s = top_start;
      l = top_len;
      if (open_len > l) begin
        l = open_len;
        s = open_start;
      end
      if (l == 9'd0 || l < {1'b0, min_len}) begin
        mid = 8'd0;
        wid = 8'd0;
        return 1'b0;
      end
      sum = {1'b0, s} + (l >> 1);
      mid = sum[7:0];
      wid = (l > 9'd255) ? 8'd255 : l[7:0];
      return 1'b1;
    endfunction

    // 127 + atan2(dx, dy) in whole degrees, vectoring cordic on fixed point
    function logic [7:0] heading_code(int dx, int dy);
      longint vx, vy, acc, sx, sy, deg, v, r;
      int k;
      vx = longint'(dy < 0 ? -dy : dy) * 64'sd16777216;
      vy = longint'(dx < 0 ? -dx : dx) * 64'sd16777216;
      acc = 0;
      if (vx != 0 || vy != 0) begin
        for (k = 0; k < 24; k++) begin
          sx = (vx < 0) ? -((-vx) >>> k) : (vx >>> k);
          sy = (vy < 0) ? -((-vy) >>> k) : (vy >>> k);
          if (vy >= 0) begin
            vx = vx + sy;
            vy = vy - sx;
            acc = acc + ATAN_STEP[k];
          end else begin
            vx = vx - sy;
            vy = vy + sx;
            acc = acc - ATAN_STEP[k];
          end
        end
      end
      deg = (dy < 0) ? (64'sd180 * 64'sd1048576) - acc : acc;
      if (dx < 0) begin
        deg = -deg;
      end
      v = longint'(LEVEL_CODE) * 64'sd1048576 + deg;
      if (v >= 0) begin
        r = (v + 64'sd524288) >>> 20;
      end else begin
        r = -(((-v) + 64'sd524288) >>> 20);
      end
      if (r < 0) begin
        r = 0;
      end
      if (r > longint'(TOP_CODE)) begin
        r = longint'(TOP_CODE);
      end
      return r[7:0];
    endfunction

    function void note_pixel(logic [7:0] px, logic [7:0] py, logic black, logic red,
                             logic fend);
      logic on_far, on_near, in_win, near_ok;
      row_side_e row;
      logic [7:0] nmid, nwid;
      frame_res_t res;
      on_far = (py == FAR_Y);
      on_near = (py == NEAR_Y);
      in_win = (px >= roi_left) && (px <= roi_right);
      if (on_far || on_near) begin
        row = on_near ? ROW_NEAR : ROW_FAR;
        if (row != side) begin
          clear_row();
          side = row;
        end
        if (in_win && black) begin
          if (open_len == 9'd0) begin
            open_start = px;
          end
          if (open_len != COUNT_CAP) begin
            open_len++;
          end
        end else begin
          close_open();
        end
        if (on_far) begin
          far_ok = row_best(far_mid, far_wid);
        end
      end else begin
        close_open();
      end
      if (py == red_row && in_win && red && red_px != COUNT_CAP) begin
        red_px++;
      end
      if (!fend) begin
        return;
      end
      near_ok = 1'b0;
      nmid = 8'd0;
      nwid = 8'd0;
      if (side == ROW_NEAR) begin
        near_ok = row_best(nmid, nwid);
      end
      res.fine_valid = near_ok && far_ok;
      res.far_center = far_ok ? far_mid : 8'd0;
      res.far_width = far_ok ? far_wid : 8'd0;
      res.near_center = nmid;
      res.near_width = nwid;
      res.angle_code = LEVEL_CODE;
      if (res.fine_valid) begin
        res.angle_code = heading_code(int'(nmid) - int'(res.far_center),
                                      int'(NEAR_Y) - int'(FAR_Y));
      end
      if (red_px >= {1'b0, red_needed_px}) begin
        if (red_run < red_frames) begin
          red_run++;
        end
      end else begin
        red_run = 4'd0;
      end
      res.red_confirmed = (red_run >= red_frames);
      expected_q.push_back(res);
      frames_expected++;
      if (res.fine_valid) angles_seen++;
      if (res.red_confirmed) red_seen++;
      // frame state starts over, the streak carries on
      clear_row();
      side = ROW_NONE;
      far_ok = 1'b0;
      far_mid = 8'd0;
      far_wid = 8'd0;
      red_px = 9'd0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      if (errors < 40) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("frame %0d %s got %0d expected %0d", frames_checked, name, got,
                         want));
      end
    endtask

    task check_result(frame_res_t got);
      frame_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with no frame pending", got));
        return;
      end
      want = expected_q.pop_front();
      compare_field("fine_valid", {7'd0, got.fine_valid}, {7'd0, want.fine_valid});
      compare_field("angle_code", got.angle_code, want.angle_code);
      compare_field("far_center", got.far_center, want.far_center);
      compare_field("near_center", got.near_center, want.near_center);
      compare_field("far_width", got.far_width, want.far_width);
      compare_field("near_width", got.near_width, want.near_width);
      compare_field("red_confirmed", {7'd0, got.red_confirmed}, {7'd0, want.red_confirmed});
      frames_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] pix_x = 8'd0;
  logic [7:0] pix_y = 8'd0;
  logic is_black = 1'b0;
  logic is_red = 1'b0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic fine_valid;
  logic [7:0] angle_code, far_center, near_center, far_width, near_width;
  logic red_confirmed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tlang_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'd0;

  line_angle_board sb = new();
  int sent_items = 0;
  int reg_writes = 0;
  bit steady = 1'b0;   // frame sent with no gaps between items

  two_row_line_angle dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // one pixel item: optional gap, then hold valid until the block takes it
  task automatic send_pixel(logic [7:0] x, logic [7:0] y, logic b, logic r, logic fe);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, MAX_IDLE));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pix_x <= x;
    pix_y <= y;
    is_black <= b;
    is_red <= r;
    frame_end <= fe;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_pixel(x, y, b, r, fe);
    sent_items++;
  endtask

  // black run of consecutive columns, no red
  task automatic send_run(logic [7:0] x0, logic [7:0] y, int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_pixel(x0 + 8'(k), y, 1'b1, 1'b0, 1'b0);
    end
  endtask

  // column inside the window most of the time
  function automatic logic [7:0] window_x();
    if (sb.roi_left <= sb.roi_right && $urandom_range(0, 9) != 0) begin
      return 8'($urandom_range(sb.roi_left, sb.roi_right));
    end
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] noise_row();
    case ($urandom_range(0, 3))
      0: return FAR_Y;
      1: return NEAR_Y;
      2: return sb.red_row;
      default: return 8'($urandom);
    endcase
  endfunction

  // a stretch of one row, scanned left to right, with black runs and gaps
  task automatic send_segment(logic [7:0] y, int count, int red_pct);
    logic [7:0] x;
    logic b;
    int k;
    x = window_x();
    b = 1'($urandom);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) b = ~b;
      send_pixel(x, y, b, $urandom_range(0, 99) < red_pct, 1'b0);
      if ($urandom_range(0, 15) == 0) begin
        x = 8'($urandom);
      end else begin
        x++;
      end
    end
  endtask

  task automatic send_frame();
    int kind, red_pct, n, k;
    bit near_first;
    steady = ($urandom_range(0, 2) == 0);
    kind = int'($urandom_range(0, 9));
    red_pct = ($urandom_range(0, 9) < 6) ? 90 : int'($urandom_range(0, 40));
    if (kind < 3) begin
      // loose pixels in any order, frame end may come early
      n = int'($urandom_range(1, 30));
      for (k = 0; k < n; k++) begin
        send_pixel(8'($urandom), noise_row(), 1'($urandom), 1'($urandom),
                   (k == n - 1) || ($urandom_range(0, 15) == 0));
      end
    end else begin
      // far row, some stray pixels, red row, near row; now and then the rows swap
      near_first = (kind == 9);
      send_segment(near_first ? NEAR_Y : FAR_Y, int'($urandom_range(0, 24)), red_pct);
      n = int'($urandom_range(0, 3));
      for (k = 0; k < n; k++) begin
        send_pixel(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
      end
      send_segment(sb.red_row, int'($urandom_range(0, 20)), red_pct);
      send_segment(near_first ? FAR_Y : NEAR_Y, int'($urandom_range(0, 24)), red_pct);
      // frame end on the near row half the time, so it may land inside the open run
      if ($urandom_range(0, 1) == 0) begin
        send_pixel(window_x(), NEAR_Y, 1'($urandom), 1'($urandom), 1'b1);
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end
    end
  endtask

  // all black and red on the far row: run length and red count both hit their cap
  task automatic send_long_run();
    int k;
    steady = 1'b1;
    for (k = 0; k < LONG_RUN; k++) begin
      send_pixel(window_x(), FAR_Y, 1'b1, 1'b1, 1'b0);
    end
    send_pixel(window_x(), FAR_Y, 1'b1, 1'b1, 1'b1);
  endtask

  // stop sending until every frame result is out and the pipeline is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase();
    int start_items, start_frames;
    start_items = sent_items;
    start_frames = sb.frames_expected;
    while (sent_items - start_items < PHASE_ITEMS ||
           sb.frames_expected - start_frames < PHASE_FRAMES) begin
      send_frame();
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  // register write, valid left high for a following write
  task automatic program_reg(logic [2:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic load_settings(logic [7:0] left, logic [7:0] right, logic [7:0] min_run,
                               logic [7:0] rrow, logic [7:0] thr, logic [3:0] frames,
                               bit spare);
    program_reg(tlang_pkg::CFG_ROI_LEFT, left);
    program_reg(tlang_pkg::CFG_ROI_RIGHT, right);
    program_reg(tlang_pkg::CFG_MIN_RUN_LENGTH, min_run);
    program_reg(tlang_pkg::CFG_RED_ROW, rrow);
    program_reg(tlang_pkg::CFG_RED_THRESHOLD, thr);
    // upper nibble of the frame count is dropped by the block
    program_reg(tlang_pkg::CFG_RED_FRAMES, {4'($urandom), frames});
    if (spare) begin
      program_reg(CFG_SPARE, 8'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall per result, with calm stretches of no stall
  initial begin : result_sink
    int stall, calm;
    frame_res_t got;
    calm = 0;
    while (rst) @(posedge clk);
    forever begin
      if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = int'($urandom_range(0, MAX_IDLE));
        if ($urandom_range(0, 7) == 0) calm = int'($urandom_range(2, 8));
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {fine_valid, angle_code, far_center, near_center, far_width, near_width,
             red_confirmed};
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window 0..159, minimum run 3, red row 65
    // far row has two runs of three, the first one wins; column 255 is outside
    send_pixel(8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    send_run(8'd0, FAR_Y, 3);
    send_pixel(8'd3, FAR_Y, 1'b0, 1'b0, 1'b0);
    send_run(8'd10, FAR_Y, 3);
    send_pixel(8'd255, FAR_Y, 1'b1, 1'b0, 1'b0);
    send_run(8'd50, NEAR_Y, 3);
    // red inside and outside the window, then frame end off every tracked row
    send_pixel(8'd100, sb.red_row, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd200, sb.red_row, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
    // near row before far row: the near run is dropped, frame end grows the far run
    send_run(8'd60, NEAR_Y, 3);
    send_run(8'd140, FAR_Y, 3);
    send_pixel(8'd159, FAR_Y, 1'b1, 1'b0, 1'b1);
    // steep line to the left, frame end extends the open near run
    send_run(8'd150, FAR_Y, 3);
    send_run(8'd0, NEAR_Y, 2);
    send_pixel(8'd2, NEAR_Y, 1'b1, 1'b0, 1'b1);
    wait_idle();

    // full window, red counted on the far row, one very long run
    load_settings(8'd0, 8'd255, 8'd1, FAR_Y, 8'd1, 4'd1, 1'b0);
    send_long_run();
    run_phase();
    // typical window, plus a write to the unused index
    load_settings(8'd20, 8'd140, 8'd3, 8'd65, 8'd8, 4'd3, 1'b1);
    run_phase();
    // largest minimum, threshold and streak length
    load_settings(8'd0, 8'd159, 8'd255, 8'd255, 8'd255, 4'd15, 1'b0);
    run_phase();
    // empty window, zero threshold, zero frames needed
    load_settings(8'd200, 8'd10, 8'd2, 8'd0, 8'd0, 4'd0, 1'b0);
    run_phase();
    // zero minimum on the full window, red counted on the near row
    load_settings(8'd0, 8'd255, 8'd0, NEAR_Y, 8'd4, 4'd2, 1'b0);
    run_phase();
    // random settings, window sometimes empty
    repeat (5) begin
      load_settings(8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)),
                    8'($urandom_range(1, 8)), noise_row(), 8'($urandom_range(1, 20)),
                    4'($urandom_range(1, 4)), 1'b0);
      run_phase();
    end

    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d frame results never arrived", sb.pending()));
    end
    $display("covered %0d pixel items in %0d frames with %0d register writes",
             sent_items, sb.frames_expected, reg_writes);
    $display("%0d frames gave an angle, %0d had red confirmed", sb.angles_seen,
             sb.red_seen);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("timed out with %0d frame results outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
rtl/tlang_pkg.sv
rtl/tlang_row_track.sv
rtl/tlang_red_count.sv
rtl/tlang_angle.sv
rtl/two_row_line_angle.sv
rtl/tlang_check.sv
sim/testbench.sv
